@@ rtl/core/gpio_pkg.sv @@
`default_nettype none

package gpio_pkg;

    localparam int unsigned P_PIN_COUNT = 16;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [3:0] REG_MODER   = 4'd0;
    localparam logic [3:0] REG_OTYPER  = 4'd1;
    localparam logic [3:0] REG_OSPEEDR = 4'd2;
    localparam logic [3:0] REG_PUPDR   = 4'd3;
    localparam logic [3:0] REG_IDR     = 4'd4;
    localparam logic [3:0] REG_ODR     = 4'd5;
    localparam logic [3:0] REG_BSRR    = 4'd6;
    localparam logic [3:0] REG_LCKR    = 4'd7;
    localparam logic [3:0] REG_AFRL    = 4'd8;
    localparam logic [3:0] REG_AFRH    = 4'd9;

    localparam logic [1:0] MODE_OUTPUT = 2'b01;
    localparam logic [1:0] MODE_ALT    = 2'b10;

    localparam logic [1:0] FIELD2_ONES = 2'h3;
    localparam logic [3:0] FIELD4_ONES = 4'hF;

    localparam int unsigned LCKR_KEY_BIT = 16;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  reg_select;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_gpio_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic [15:0] drive_enable;
        logic        lock_active;
    } t_gpio_out;

    function automatic logic [15:0] present_pins();
        logic [15:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < P_PIN_COUNT) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [15:0] P_PIN_MASK = present_pins();

    function automatic logic [31:0] widen2(input logic [15:0] pins);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (pins[i]) begin
                m[2*i +: 2] = FIELD2_ONES;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] widen4(input logic [7:0] pins);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (pins[i]) begin
                m[4*i +: 4] = FIELD4_ONES;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gpio_lock.sv @@
`default_nettype none

module gpio_lock (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire logic [16:0] i_data,
    output logic             o_key,
    output logic             o_key_next,
    output logic [15:0]      o_pattern
);
    import gpio_pkg::*;

    localparam logic [1:0] LK_IDLE   = 2'd0;
    localparam logic [1:0] LK_FIRST  = 2'd1;
    localparam logic [1:0] LK_SECOND = 2'd2;

    logic [1:0]  r_stage, n_stage;
    logic        r_key, n_key;
    logic [15:0] r_pattern, n_pattern;
    logic [15:0] pat;
    logic        k;
    logic        same;

    assign pat  = i_data[15:0] & P_PIN_MASK;
    assign k    = i_data[LCKR_KEY_BIT];
    assign same = (pat == r_pattern);

    always_comb begin
        n_stage   = r_stage;
        n_key     = r_key;
        n_pattern = r_pattern;
        if (i_wr && !r_key) begin
            n_pattern = pat;
            priority if (r_stage == LK_FIRST && !k && same) begin
                n_stage = LK_SECOND;
            end else if (r_stage == LK_SECOND && k && same) begin
                n_key   = 1'b1;
                n_stage = LK_IDLE;
            end else begin
                n_stage = k ? LK_FIRST : LK_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= LK_IDLE;
            r_key     <= 1'b0;
            r_pattern <= '0;
        end else begin
            r_stage   <= n_stage;
            r_key     <= n_key;
            r_pattern <= n_pattern;
        end
    end

    assign o_key      = r_key;
    assign o_key_next = n_key;
    assign o_pattern  = r_pattern;

endmodule

`default_nettype wire

@@ rtl/core/gpio_regs.sv @@
`default_nettype none

module gpio_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire gpio_pkg::t_gpio_in  i_word,
    output gpio_pkg::t_gpio_out      o_result
);
    import gpio_pkg::*;

    logic [31:0] r_mode, n_mode;
    logic [15:0] r_type, n_type;
    logic [31:0] r_speed, n_speed;
    logic [31:0] r_pull, n_pull;
    logic [31:0] r_afrl, n_afrl;
    logic [31:0] r_afrh, n_afrh;
    logic [15:0] r_odr, n_odr;
    logic [15:0] r_idr;

    logic        lock_key;
    logic        lock_key_next;
    logic [15:0] lock_pattern;
    logic [15:0] open_pins;
    logic [31:0] mask2;
    logic [31:0] mask_lo;
    logic [31:0] mask_hi;
    logic        wr;
    logic [31:0] wd;
    logic [31:0] rd;
    logic [15:0] en;

    assign wr        = i_fire && (i_word.opcode == OP_WRITE);
    assign wd        = i_word.write_data;
    assign open_pins = lock_key ? (P_PIN_MASK & ~lock_pattern) : P_PIN_MASK;
    assign mask2     = widen2(open_pins);
    assign mask_lo   = widen4(open_pins[7:0]);
    assign mask_hi   = widen4(open_pins[15:8]);

    gpio_lock u_lock (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr && (i_word.reg_select == REG_LCKR)),
        .i_data     (wd[16:0]),
        .o_key      (lock_key),
        .o_key_next (lock_key_next),
        .o_pattern  (lock_pattern)
    );

    always_comb begin
        n_mode  = r_mode;
        n_type  = r_type;
        n_speed = r_speed;
        n_pull  = r_pull;
        n_afrl  = r_afrl;
        n_afrh  = r_afrh;
        n_odr   = r_odr;
        if (wr) begin
            unique case (i_word.reg_select)
                REG_MODER:   n_mode  = (r_mode & ~mask2) | (wd & mask2);
                REG_OTYPER:  n_type  = (r_type & ~open_pins) | (wd[15:0] & open_pins);
                REG_OSPEEDR: n_speed = (r_speed & ~mask2) | (wd & mask2);
                REG_PUPDR:   n_pull  = (r_pull & ~mask2) | (wd & mask2);
                REG_ODR:     n_odr   = wd[15:0] & P_PIN_MASK;
                REG_BSRR:    n_odr   = ((r_odr & ~wd[31:16]) | wd[15:0]) & P_PIN_MASK;
                REG_AFRL:    n_afrl  = (r_afrl & ~mask_lo) | (wd & mask_lo);
                REG_AFRH:    n_afrh  = (r_afrh & ~mask_hi) | (wd & mask_hi);
                default:     ;
            endcase
        end
    end

    always_comb begin
        rd = '0;
        if (i_word.opcode == OP_READ) begin
            unique case (i_word.reg_select)
                REG_MODER:   rd = r_mode;
                REG_OTYPER:  rd = {16'b0, r_type};
                REG_OSPEEDR: rd = r_speed;
                REG_PUPDR:   rd = r_pull;
                REG_IDR:     rd = {16'b0, r_idr};
                REG_ODR:     rd = {16'b0, r_odr};
                REG_LCKR:    rd = {15'b0, lock_key, lock_pattern};
                REG_AFRL:    rd = r_afrl;
                REG_AFRH:    rd = r_afrh;
                default:     rd = '0;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            en[i] = (n_mode[2*i +: 2] == MODE_OUTPUT) || (n_mode[2*i +: 2] == MODE_ALT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_type  <= '0;
            r_speed <= '0;
            r_pull  <= '0;
            r_afrl  <= '0;
            r_afrh  <= '0;
            r_odr   <= '0;
            r_idr   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_type  <= n_type;
            r_speed <= n_speed;
            r_pull  <= n_pull;
            r_afrl  <= n_afrl;
            r_afrh  <= n_afrh;
            r_odr   <= n_odr;
            r_idr   <= i_word.pin_levels & P_PIN_MASK;
        end
    end

    assign o_result.read_data    = rd;
    assign o_result.pin_drive    = n_odr;
    assign o_result.drive_enable = en;
    assign o_result.lock_active  = lock_key_next;

endmodule

`default_nettype wire

@@ rtl/core/gpio_port_register_block_top.sv @@
`default_nettype none

// GPIO port register block: one bus word in, one result word out. Each word is
// held in an input register, handled by a single pass of masking logic against
// the port registers, and its result is held in an output register, so a
// result reaches the output by way of the input register and then the output
// register, and a new word is taken every cycle while the output side does not
// stall. The rate is set by that one register-to-register pass; the output
// register lets the next word enter while a finished result waits.
module gpio_port_register_block_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire gpio_pkg::t_gpio_in  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output gpio_pkg::t_gpio_out      o_out_word
);
    import gpio_pkg::*;

    logic      r_in_valid;
    t_gpio_in  r_in_word;
    logic      r_out_valid;
    t_gpio_out r_out_word;
    t_gpio_out result;
    logic      advance;
    logic      load;
    logic      fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign load       = !r_in_valid || advance;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = !load;

    gpio_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_in_valid  <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_word <= i_in_word;
        end
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

@@ tb/sv/gpio_port_register_block_top_test.sv @@
`timescale 1ns / 100ps

module gpio_port_register_block_top_test;
    import gpio_pkg::*;

    localparam logic [3:0]  REG_SPARE_LO  = 4'd10;
    localparam logic [3:0]  REG_SPARE_HI  = 4'd15;
    localparam int unsigned RANDOM_ITEMS  = 1830;
    localparam int unsigned LOCK_OPEN_AT  = 1100;
    localparam int unsigned DRAIN_AT      = 900;
    localparam int unsigned HOLD_AT       = 400;
    localparam int unsigned HOLD_CYCLES   = 90;
    localparam int unsigned WATCHDOG      = 2000;
    localparam int unsigned DIR_COUNT     = 26;

    typedef enum logic [1:0] {
        LOCK_IDLE      = 2'd0,
        LOCK_GOT_SET   = 2'd1,
        LOCK_GOT_CLEAR = 2'd2
    } t_lock_stage;

    typedef struct packed {
        logic        op;
        logic [3:0]  sel;
        logic [31:0] data;
        logic [15:0] lv;
        logic        fixed;
        logic [31:0] rd;
        logic [15:0] drv;
        logic [15:0] en;
        logic        lk;
    } t_dir_row;

    typedef struct {
        t_gpio_in  word;
        bit        fixed;
        t_gpio_out want;
    } t_bus_op;

    localparam t_dir_row DIRECTED_ROWS [DIR_COUNT] = '{
        '{OP_READ,  REG_MODER,    32'h0000_0000, 16'hFFFF, 1'b1,
          32'h0000_0000, 16'h0000, 16'h0000, 1'b0},
        '{OP_READ,  REG_IDR,      32'h0000_0000, 16'h0000, 1'b1,
          32'h0000_FFFF, 16'h0000, 16'h0000, 1'b0},
        '{OP_WRITE, REG_MODER,    32'hFFFF_FFFF, 16'h0000, 1'b1,
          32'h0000_0000, 16'h0000, 16'h0000, 1'b0},
        '{OP_WRITE, REG_MODER,    32'h5555_5555, 16'hFFFF, 1'b1,
          32'h0000_0000, 16'h0000, 16'hFFFF, 1'b0},
        '{OP_WRITE, REG_MODER,    32'hAAAA_AAAA, 16'h0000, 1'b1,
          32'h0000_0000, 16'h0000, 16'hFFFF, 1'b0},
        '{OP_WRITE, REG_MODER,    32'h0000_0000, 16'hFFFF, 1'b1,
          32'h0000_0000, 16'h0000, 16'h0000, 1'b0},
        '{OP_WRITE, REG_ODR,      32'hFFFF_FFFF, 16'h0000, 1'b1,
          32'h0000_0000, 16'hFFFF, 16'h0000, 1'b0},
        '{OP_WRITE, REG_BSRR,     32'hFFFF_0000, 16'hFFFF, 1'b1,
          32'h0000_0000, 16'h0000, 16'h0000, 1'b0},
        '{OP_WRITE, REG_BSRR,     32'hFFFF_FFFF, 16'h0000, 1'b1,
          32'h0000_0000, 16'hFFFF, 16'h0000, 1'b0},
        '{OP_READ,  REG_BSRR,     32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          32'h0000_0000, 16'hFFFF, 16'h0000, 1'b0},
        '{OP_WRITE, REG_BSRR,     32'h00FF_0F00, 16'h5A5A, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_IDR,      32'hFFFF_FFFF, 16'h8001, 1'b0, '0, '0, '0, 1'b0},
        '{OP_READ,  REG_IDR,      32'h0000_0000, 16'h7FFE, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_OTYPER,   32'hFFFF_FFFF, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_OSPEEDR,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_PUPDR,    32'hFFFF_FFFF, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_AFRL,     32'hFFFF_FFFF, 16'h1234, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_AFRH,     32'h89AB_CDEF, 16'hFEDC, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0, '0, '0, 1'b0},
        '{OP_READ,  REG_SPARE_LO, 32'h0000_0000, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{OP_READ,  REG_AFRH,     32'h0000_0000, 16'h00FF, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_LCKR,     32'h0001_0F0F, 16'hFF00, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_LCKR,     32'h0001_0F0F, 16'h0F0F, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_LCKR,     32'h0000_0F0E, 16'hF0F0, 1'b0, '0, '0, '0, 1'b0},
        '{OP_WRITE, REG_LCKR,     32'hFFFE_FFFF, 16'h3C3C, 1'b0, '0, '0, '0, 1'b0},
        '{OP_READ,  REG_LCKR,     32'h0000_0000, 16'hC3C3, 1'b0, '0, '0, '0, 1'b0}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_gpio_in  in_word;
    logic      out_valid;
    logic      out_stall;
    t_gpio_out out_word;

    logic [31:0] shadow_mode;
    logic [15:0] shadow_otype;
    logic [31:0] shadow_speed;
    logic [31:0] shadow_pull;
    logic [31:0] shadow_afr [2];
    logic [15:0] shadow_odr;
    logic [15:0] shadow_idr;
    logic [15:0] shadow_lock_pat;
    logic        shadow_lock_key;
    t_lock_stage shadow_lock_stage;

    t_bus_op     bus_plan [$];
    t_gpio_out   result_fifo [$];
    t_gpio_out   want_word;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned idle_cycles;

    gpio_port_register_block_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 40) begin
            $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        end
        mismatches++;
    endtask

    function automatic logic [31:0] pin_fields2(input logic [15:0] pins);
        logic [31:0] m;
        m = '0;
        for (int p = 0; p < 16; p++) begin
            if (pins[p]) begin
                m[2*p +: 2] = FIELD2_ONES;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] pin_fields4(input logic [7:0] pins);
        logic [31:0] m;
        m = '0;
        for (int p = 0; p < 8; p++) begin
            if (pins[p]) begin
                m[4*p +: 4] = FIELD4_ONES;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] masked_update(input logic [31:0] old,
                                                  input logic [31:0] val,
                                                  input logic [31:0] mask);
        return (old & ~mask) | (val & mask);
    endfunction

    function automatic void shadow_clear();
        shadow_mode       = '0;
        shadow_otype      = '0;
        shadow_speed      = '0;
        shadow_pull       = '0;
        shadow_afr[0]     = '0;
        shadow_afr[1]     = '0;
        shadow_odr        = '0;
        shadow_idr        = '0;
        shadow_lock_pat   = '0;
        shadow_lock_key   = 1'b0;
        shadow_lock_stage = LOCK_IDLE;
    endfunction

    function automatic t_gpio_out gpio_predict(input t_gpio_in w);
        t_gpio_out   r;
        logic [15:0] open_pins;
        logic [15:0] pat;
        logic        key;
        logic [1:0]  field;
        r = '0;
        open_pins = shadow_lock_key ? (P_PIN_MASK & ~shadow_lock_pat) : P_PIN_MASK;
        if (w.opcode == OP_READ) begin
            case (w.reg_select)
                REG_MODER:   r.read_data = shadow_mode;
                REG_OTYPER:  r.read_data = {16'h0, shadow_otype};
                REG_OSPEEDR: r.read_data = shadow_speed;
                REG_PUPDR:   r.read_data = shadow_pull;
                REG_IDR:     r.read_data = {16'h0, shadow_idr};
                REG_ODR:     r.read_data = {16'h0, shadow_odr};
                REG_LCKR:    r.read_data = {15'h0, shadow_lock_key, shadow_lock_pat};
                REG_AFRL:    r.read_data = shadow_afr[0];
                REG_AFRH:    r.read_data = shadow_afr[1];
                default:     r.read_data = '0;
            endcase
        end else begin
            case (w.reg_select)
                REG_MODER: begin
                    shadow_mode = masked_update(shadow_mode, w.write_data, pin_fields2(open_pins));
                end
                REG_OTYPER: begin
                    shadow_otype = (shadow_otype & ~open_pins) | (w.write_data[15:0] & open_pins);
                end
                REG_OSPEEDR: begin
                    shadow_speed = masked_update(shadow_speed, w.write_data,
                                                 pin_fields2(open_pins));
                end
                REG_PUPDR: begin
                    shadow_pull = masked_update(shadow_pull, w.write_data, pin_fields2(open_pins));
                end
                REG_ODR: begin
                    shadow_odr = w.write_data[15:0] & P_PIN_MASK;
                end
                REG_BSRR: begin
                    shadow_odr = ((shadow_odr & ~w.write_data[31:16]) | w.write_data[15:0])
                                 & P_PIN_MASK;
                end
                REG_LCKR: begin
                    if (!shadow_lock_key) begin
                        pat = w.write_data[15:0] & P_PIN_MASK;
                        key = w.write_data[LCKR_KEY_BIT];
                        if (shadow_lock_stage == LOCK_GOT_SET && !key
                                && pat == shadow_lock_pat) begin
                            shadow_lock_stage = LOCK_GOT_CLEAR;
                        end else if (shadow_lock_stage == LOCK_GOT_CLEAR && key
                                && pat == shadow_lock_pat) begin
                            shadow_lock_key   = 1'b1;
                            shadow_lock_stage = LOCK_IDLE;
                        end else begin
                            shadow_lock_stage = key ? LOCK_GOT_SET : LOCK_IDLE;
                        end
                        shadow_lock_pat = pat;
                    end
                end
                REG_AFRL: begin
                    shadow_afr[0] = masked_update(shadow_afr[0], w.write_data,
                                                  pin_fields4(open_pins[7:0]));
                end
                REG_AFRH: begin
                    shadow_afr[1] = masked_update(shadow_afr[1], w.write_data,
                                                  pin_fields4(open_pins[15:8]));
                end
                default: ;
            endcase
        end
        shadow_idr = w.pin_levels & P_PIN_MASK;
        for (int p = 0; p < 16; p++) begin
            field = shadow_mode[2*p +: 2];
            r.drive_enable[p] = (field == MODE_OUTPUT) || (field == MODE_ALT);
        end
        r.pin_drive   = shadow_odr;
        r.lock_active = shadow_lock_key;
        return r;
    endfunction

    task automatic plan_push(input logic op, input logic [3:0] sel, input logic [31:0] data);
        t_bus_op b;
        b.word.opcode     = op;
        b.word.reg_select = sel;
        b.word.write_data = data;
        b.word.pin_levels = 16'($urandom_range(0, 65535));
        b.fixed           = 1'b0;
        b.want            = '0;
        bus_plan.push_back(b);
    endtask

    task automatic plan_random(input int unsigned count);
        int unsigned made;
        int unsigned pick;
        int unsigned flaw;
        int unsigned fill;
        logic [15:0] pat;
        logic [31:0] data;
        logic [3:0]  sel;
        logic        key;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                // key sequence 1,0,1; broken on purpose until the lock is let through
                pat  = 16'($urandom_range(0, 65535));
                flaw = (made < LOCK_OPEN_AT) ? $urandom_range(1, 4) : 0;
                for (int k = 0; k < 3; k++) begin
                    key  = (k != 1);
                    data = $urandom;
                    if ((flaw == 1 && k == 1) || (flaw == 2 && k == 2)) begin
                        key = !key;
                    end
                    if ((flaw == 3 && k == 1) || (flaw == 4 && k == 2)) begin
                        pat[$urandom_range(0, 15)] ^= 1'b1;
                    end
                    data[LCKR_KEY_BIT] = key;
                    data[15:0]         = pat;
                    plan_push(OP_WRITE, REG_LCKR, data);
                    made++;
                    fill = (k < 2) ? $urandom_range(0, 2) : 0;
                    for (int f = 0; f < fill; f++) begin
                        sel = 4'($urandom_range(0, 8));
                        if (sel >= REG_LCKR) begin
                            sel = sel + 4'd1;
                        end
                        plan_push(1'($urandom_range(0, 1)), sel, $urandom);
                        made++;
                    end
                end
            end else begin
                sel  = (pick < 90) ? 4'($urandom_range(0, 9))
                                   : 4'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
                pick = $urandom_range(0, 9);
                data = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'h0 : $urandom;
                plan_push(1'($urandom_range(0, 1)), sel, data);
                made++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid === 1'b1 && !out_stall) begin
                results_seen++;
                if (result_fifo.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", out_word.read_data, '0);
                end else begin
                    want_word = result_fifo.pop_front();
                    if (out_word.read_data !== want_word.read_data) begin
                        flag_mismatch("read_data", out_word.read_data, want_word.read_data);
                    end
                    if (out_word.pin_drive !== want_word.pin_drive) begin
                        flag_mismatch("pin_drive", {16'h0, out_word.pin_drive},
                                      {16'h0, want_word.pin_drive});
                    end
                    if (out_word.drive_enable !== want_word.drive_enable) begin
                        flag_mismatch("drive_enable", {16'h0, out_word.drive_enable},
                                      {16'h0, want_word.drive_enable});
                    end
                    if (out_word.lock_active !== want_word.lock_active) begin
                        flag_mismatch("lock_active", {31'h0, out_word.lock_active},
                                      {31'h0, want_word.lock_active});
                    end
                end
            end
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG) begin
                    $display("watchdog: no word moved for %0d cycles", idle_cycles);
                    $display("FAIL gpio_port_register_block_top");
                    $finish;
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned taken;
        int unsigned hold;
        out_stall = 1'b0;
        taken     = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            hold = ((taken / 150) % 5 == 4) ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT) begin
                hold = HOLD_CYCLES;
            end
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            taken++;
        end
    end

    initial begin : bus_master
        t_bus_op     b;
        t_gpio_out   predicted;
        int unsigned gap;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        shadow_clear();
        foreach (DIRECTED_ROWS[r]) begin
            b.word.opcode     = DIRECTED_ROWS[r].op;
            b.word.reg_select = DIRECTED_ROWS[r].sel;
            b.word.write_data = DIRECTED_ROWS[r].data;
            b.word.pin_levels = DIRECTED_ROWS[r].lv;
            b.fixed           = DIRECTED_ROWS[r].fixed;
            b.want.read_data    = DIRECTED_ROWS[r].rd;
            b.want.pin_drive    = DIRECTED_ROWS[r].drv;
            b.want.drive_enable = DIRECTED_ROWS[r].en;
            b.want.lock_active  = DIRECTED_ROWS[r].lk;
            bus_plan.push_back(b);
        end
        plan_random(RANDOM_ITEMS);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int idx = 0; idx < bus_plan.size(); idx++) begin
            gap = ((idx / 200) % 4 == 3) ? 0 : $urandom_range(0, 9);
            if (idx == DRAIN_AT || gap != 0) begin
                in_valid <= 1'b0;
                if (idx == DRAIN_AT) begin
                    while (result_fifo.size() != 0) @(posedge clk);
                    @(negedge clk);
                end
                repeat (gap) @(negedge clk);
            end
            in_word  <= bus_plan[idx].word;
            in_valid <= 1'b1;
            @(posedge clk);
            while (in_stall !== 1'b0) @(posedge clk);
            predicted = gpio_predict(bus_plan[idx].word);
            result_fifo.push_back(bus_plan[idx].fixed ? bus_plan[idx].want : predicted);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        while (result_fifo.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (result_fifo.size() != 0) begin
            flag_mismatch("results never delivered", result_fifo.size(), '0);
        end
        $display("ran %0d bus words (%0d from the table), checked %0d results, %0d mismatches",
                 bus_plan.size(), DIR_COUNT, results_seen, mismatches);
        $display("config lock engaged during run: %0d, final locked pins %h",
                 shadow_lock_key, shadow_lock_pat);
        if (mismatches == 0) begin
            $display("PASS gpio_port_register_block_top");
        end else begin
            $display("FAIL gpio_port_register_block_top");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/gpio_pkg.sv
rtl/core/gpio_lock.sv
rtl/core/gpio_regs.sv
rtl/core/gpio_port_register_block_top.sv
tb/sv/gpio_port_register_block_top_test.sv
